[rtl/assert_macros.svh]
// Assertion macros for the RTL of the spanning-tree block, used by mstk_dp.
// Expects signals named clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MSTK_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define MSTK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define MSTK_ASSERT(lbl, expr)
`define MSTK_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[rtl/mstk_pkg.sv]
// Shared types and constants of the spanning-tree block.
// Used by mstk_ctrl, mstk_dp and the top level; no dependencies.
package mstk_pkg;

  localparam int ENDP_BITS = 6;
  localparam int VC_BITS   = 7;
  localparam int OUT_WBITS = 32;

  typedef struct packed {
    logic load;
    logic clr;
    logic scan_init;
    logic scan;
    logic next_key;
    logic root_a;
    logic root_b;
    logic root_rd;
    logic root_step;
    logic save_ra;
    logic unite;
    logic run_done;
    logic emit_init;
    logic emit_rd;
    logic out_edge;
    logic out_flag;
    logic flag_nc;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic found;
    logic in_range;
    logic root_hit;
    logic roots_differ;
    logic tree_full;
    logic tree_empty;
    logic emit_last;
    logic out_busy;
  } sts_t;

endpackage

[rtl/mstk_ctrl.sv]
// Sequencer of the spanning-tree block: load, clear, scan, union, emit.
// Depends on mstk_pkg; drives the datapath through cmd_t, reads sts_t.
module mstk_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           last_edge,
  output logic           in_ready,
  input  mstk_pkg::sts_t sts,
  output mstk_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    LOAD, CLEAR, TEST, SCAN, CHECK, FA_RD, FA_CHK, FB_RD, FB_CHK,
    FINISH, FLAG, EMIT_RD, EMIT_LD
  } state_t;

  state_t state, state_next;
  logic   flag_nc, flag_nc_next;

  always_comb begin
    state_next   = state;
    flag_nc_next = flag_nc;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last_edge) state_next = CLEAR;
        end
      end
      CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = TEST;
      end
      TEST: begin
        if (sts.tree_full) begin
          state_next = FINISH;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = SCAN;
        end
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = CHECK;
      end
      CHECK: begin
        if (!sts.found) begin
          state_next = FINISH;
        end else begin
          cmd.next_key = 1'b1;
          if (sts.in_range) begin
            cmd.root_a = 1'b1;
            state_next = FA_RD;
          end else begin
            state_next = TEST;
          end
        end
      end
      FA_RD: begin
        cmd.root_rd = 1'b1;
        state_next  = FA_CHK;
      end
      FA_CHK: begin
        if (sts.root_hit) begin
          cmd.save_ra = 1'b1;
          cmd.root_b  = 1'b1;
          state_next  = FB_RD;
        end else begin
          cmd.root_step = 1'b1;
          state_next    = FA_RD;
        end
      end
      FB_RD: begin
        cmd.root_rd = 1'b1;
        state_next  = FB_CHK;
      end
      FB_CHK: begin
        if (sts.root_hit) begin
          cmd.unite  = sts.roots_differ;
          state_next = TEST;
        end else begin
          cmd.root_step = 1'b1;
          state_next    = FB_RD;
        end
      end
      FINISH: begin
        cmd.run_done = 1'b1;
        if (!sts.tree_full) begin
          flag_nc_next = 1'b1;
          state_next   = FLAG;
        end else if (sts.tree_empty) begin
          flag_nc_next = 1'b0;
          state_next   = FLAG;
        end else begin
          cmd.emit_init = 1'b1;
          state_next    = EMIT_RD;
        end
      end
      FLAG: begin
        if (!sts.out_busy) begin
          cmd.out_flag = 1'b1;
          cmd.flag_nc  = flag_nc;
          state_next   = LOAD;
        end
      end
      EMIT_RD: begin
        if (!sts.out_busy) begin
          cmd.emit_rd = 1'b1;
          state_next  = EMIT_LD;
        end
      end
      EMIT_LD: begin
        cmd.out_edge = 1'b1;
        state_next   = sts.emit_last ? LOAD : EMIT_RD;
      end
      default: state_next = LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= LOAD;
      flag_nc <= 1'b0;
    end else begin
      state   <= state_next;
      flag_nc <= flag_nc_next;
    end
  end

endmodule

[rtl/mstk_dp.sv]
// Datapath of the spanning-tree block: edge store, ordered scan, parent
// table, chosen-edge list and output register. Depends on mstk_pkg.
`include "assert_macros.svh"
module mstk_dp #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mstk_pkg::cmd_t                       cmd,
  output mstk_pkg::sts_t                       sts,
  input  logic                                 vertex_count_we,
  input  logic [mstk_pkg::VC_BITS-1:0]         vertex_count,
  input  logic [mstk_pkg::ENDP_BITS-1:0]       end_a,
  input  logic [mstk_pkg::ENDP_BITS-1:0]       end_b,
  input  logic signed [mstk_pkg::OUT_WBITS-1:0] edge_weight,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mstk_pkg::ENDP_BITS-1:0]       tree_end_a,
  output logic [mstk_pkg::ENDP_BITS-1:0]       tree_end_b,
  output logic signed [mstk_pkg::OUT_WBITS-1:0] tree_weight,
  output logic                                 edge_present,
  output logic                                 not_connected,
  output logic                                 last_result
);

  localparam int EB = mstk_pkg::ENDP_BITS;
  localparam int OB = mstk_pkg::OUT_WBITS;
  localparam int VB = mstk_pkg::VC_BITS;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int TW = $clog2(MAX_EDGES + 1);
  localparam int WB = WEIGHT_BITS;
  localparam int SW = 2 * EB + WB;
  localparam int LW = 2 * EB + OB;

  // configuration
  logic [VB-1:0] vc_reg, v_eff;
  always_ff @(posedge clk) begin
    if (rst) vc_reg <= VB'(1);
    else if (vertex_count_we) vc_reg <= vertex_count;
  end
  assign v_eff = (vc_reg == '0) ? VB'(1) :
                 (vc_reg > VB'(MAX_VERTICES)) ? VB'(MAX_VERTICES) : vc_reg;

  // weight saturation on load, and back to the output width
  logic signed [WB-1:0] w_sat;
  logic signed [WB-1:0] best_w;
  logic signed [OB-1:0] best_w_out;
  if (WB >= OB) begin : g_wide
    assign w_sat      = WB'(edge_weight);
    assign best_w_out = best_w[OB-1:0];
  end else begin : g_narrow
    logic fits;
    assign fits  = (edge_weight[OB-1:WB-1] == {(OB-WB+1){edge_weight[OB-1]}});
    assign w_sat = fits ? edge_weight[WB-1:0] :
                   edge_weight[OB-1] ? {1'b1, {(WB-1){1'b0}}} : {1'b0, {(WB-1){1'b1}}};
    assign best_w_out = OB'(best_w);
  end

  // edge store
  logic [SW-1:0] store [MAX_EDGES];
  logic [SW-1:0] store_q;
  logic [TW-1:0] total, scan_addr;
  logic          store_full;
  assign store_full = (total == TW'(MAX_EDGES));

  always_ff @(posedge clk) begin
    if (cmd.load && !store_full) store[total[EW-1:0]] <= {end_a, end_b, w_sat};
    if (cmd.scan && scan_addr != total) store_q <= store[scan_addr[EW-1:0]];
  end

  // ordered scan: smallest (weight, index) key above the previous one
  logic [EB-1:0]        rd_a, rd_b, best_a, best_b;
  logic signed [WB-1:0] rd_w, prev_w;
  logic [EW-1:0]        rd_idx, best_i, prev_i;
  logic                 rd_vld, found, prev_valid, eligible, take;
  assign rd_a = store_q[SW-1 -: EB];
  assign rd_b = store_q[SW-EB-1 -: EB];
  assign rd_w = store_q[WB-1:0];
  assign eligible = !prev_valid || (rd_w > prev_w) ||
                    ((rd_w == prev_w) && (rd_idx > prev_i));
  // later index never wins a tie, scan runs in load order
  assign take = cmd.scan && rd_vld && eligible && (!found || (rd_w < best_w));

  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      scan_addr  <= '0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
      prev_valid <= 1'b0;
    end else begin
      if (cmd.load && !store_full) total <= total + TW'(1);
      if (cmd.run_done) begin
        total      <= '0;
        prev_valid <= 1'b0;
      end
      if (cmd.next_key) prev_valid <= 1'b1;
      if (cmd.scan_init) begin
        scan_addr <= '0;
        rd_vld    <= 1'b0;
        found     <= 1'b0;
      end else if (cmd.scan) begin
        rd_vld <= (scan_addr != total);
        if (scan_addr != total) scan_addr <= scan_addr + TW'(1);
        if (take) found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && scan_addr != total) rd_idx <= scan_addr[EW-1:0];
    if (take) begin
      best_a <= rd_a;
      best_b <= rd_b;
      best_w <= rd_w;
      best_i <= rd_idx;
    end
    if (cmd.next_key) begin
      prev_w <= best_w;
      prev_i <= best_i;
    end
  end

  // union-find parent table
  logic [VW-1:0] parent [MAX_VERTICES];
  logic [VW-1:0] par_q, x, ra, ci;
  logic [VW-1:0] chosen, k;

  always_ff @(posedge clk) begin
    if (cmd.clr) parent[ci] <= ci;
    else if (cmd.unite) parent[ra] <= x;
    if (cmd.root_rd) par_q <= parent[x];
    if (cmd.root_a) x <= VW'(best_a);
    else if (cmd.root_b) x <= VW'(best_b);
    else if (cmd.root_step) x <= par_q;
    if (cmd.save_ra) ra <= x;
  end

  // chosen-edge list
  logic [LW-1:0] list [MAX_VERTICES];
  logic [LW-1:0] list_q;
  always_ff @(posedge clk) begin
    if (cmd.unite) list[chosen] <= {best_a, best_b, best_w_out};
    if (cmd.emit_rd) list_q <= list[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ci        <= '0;
      chosen    <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr) begin
        ci     <= (ci == VW'(MAX_VERTICES - 1)) ? '0 : ci + VW'(1);
        chosen <= '0;
      end
      if (cmd.unite) chosen <= chosen + VW'(1);
      if (cmd.emit_init) k <= '0;
      else if (cmd.out_edge) k <= k + VW'(1);
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.out_edge || cmd.out_flag) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_edge) begin
      tree_end_a    <= list_q[LW-1 -: EB];
      tree_end_b    <= list_q[LW-EB-1 -: EB];
      tree_weight   <= list_q[OB-1:0];
      edge_present  <= 1'b1;
      not_connected <= 1'b0;
      last_result   <= sts.emit_last;
    end else if (cmd.out_flag) begin
      tree_end_a    <= '0;
      tree_end_b    <= '0;
      tree_weight   <= '0;
      edge_present  <= 1'b0;
      not_connected <= cmd.flag_nc;
      last_result   <= 1'b1;
    end
  end

  always_comb begin
    sts.clr_last     = (ci == VW'(MAX_VERTICES - 1));
    sts.scan_done    = (scan_addr == total) && !rd_vld;
    sts.found        = found;
    sts.in_range     = (VB'(best_a) < v_eff) && (VB'(best_b) < v_eff);
    sts.root_hit     = (par_q == x);
    sts.roots_differ = (ra != x);
    sts.tree_full    = (8'(chosen) + 8'd1 == 8'(v_eff));
    sts.tree_empty   = (chosen == '0);
    sts.emit_last    = (8'(k) + 8'd1 == 8'(chosen));
    sts.out_busy     = out_valid;
  end

  `MSTK_ASSERT(total_bound, total <= TW'(MAX_EDGES))
  `MSTK_ASSERT_IMP(unite_two_roots, cmd.unite, ra != x)
  `MSTK_ASSERT_IMP(out_load_free, cmd.out_edge || cmd.out_flag, !out_valid)
  `MSTK_ASSERT_IMP(emit_in_list, cmd.emit_rd, k < chosen)

endmodule

[rtl/minimum_spanning_tree_kruskal.sv]
// Kruskal minimum spanning tree over a loaded edge list. Edges load one per
// cycle while in_ready is high; the edge marked last_edge starts the search,
// and in_ready stays low until the final result sits in the output register.
// The search first clears the parent table, then for each edge in (weight,
// load order) runs a full pass over the edge store to pick it, checks the
// key and the endpoint range, and walks both endpoints to their roots one
// parent hop at a time; an edge with an endpoint out of range is skipped.
// Each tree edge is then emitted from the chosen list; a new result is
// loaded only after the previous one has been taken. A disconnected graph
// gives one result with not_connected set.
// Uses mstk_ctrl and mstk_dp.
module minimum_spanning_tree_kruskal #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  vertex_count_we,
  input  logic [mstk_pkg::VC_BITS-1:0]          vertex_count,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [mstk_pkg::ENDP_BITS-1:0]        end_a,
  input  logic [mstk_pkg::ENDP_BITS-1:0]        end_b,
  input  logic signed [mstk_pkg::OUT_WBITS-1:0] edge_weight,
  input  logic                                  last_edge,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mstk_pkg::ENDP_BITS-1:0]        tree_end_a,
  output logic [mstk_pkg::ENDP_BITS-1:0]        tree_end_b,
  output logic signed [mstk_pkg::OUT_WBITS-1:0] tree_weight,
  output logic                                  edge_present,
  output logic                                  not_connected,
  output logic                                  last_result
);

  mstk_pkg::cmd_t cmd;
  mstk_pkg::sts_t sts;

  mstk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_edge (last_edge),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mstk_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .vertex_count_we (vertex_count_we),
    .vertex_count    (vertex_count),
    .end_a           (end_a),
    .end_b           (end_b),
    .edge_weight     (edge_weight),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .tree_end_a      (tree_end_a),
    .tree_end_b      (tree_end_b),
    .tree_weight     (tree_weight),
    .edge_present    (edge_present),
    .not_connected   (not_connected),
    .last_result     (last_result)
  );

endmodule
